FILE: hdl/fkr_pkg.sv
// shared types and codes for the keyed-removal queue
package fkr_pkg;

	localparam logic [1:0] CMD_PUSH   = 2'd0;
	localparam logic [1:0] CMD_POP    = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;

	localparam logic [1:0] RC_OK        = 2'd0;
	localparam logic [1:0] RC_EMPTY     = 2'd1;
	localparam logic [1:0] RC_FULL      = 2'd2;
	localparam logic [1:0] RC_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic push;
		logic pop;
		logic search;
	} cell_ctrl_t;

endpackage

FILE: hdl/fifo_with_keyed_removal.sv
// keyed-removal queue top: row of slot cells, count and registered result
//
//  channel  | valid     | stall     | payload
//  ---------+-----------+-----------+----------------------------------------------
//  input    | in_valid  | in_stall  | cmd, id
//  output   | out_valid | out_stall | result_code, removed_id, entry_total, is_empty
//
// one transaction per cycle while in_stall is low; its result is registered and shows the cycle after
// the ripple of the first-match chain through the row of cells sets the clock period
// reset clears the entry count and the output valid; slot contents are not cleared
// in_stall is high while a result waits and out_stall holds it
module fifo_with_keyed_removal #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [15:0] id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_code,
	output logic [15:0] removed_id,
	output logic [4:0]  entry_total,
	output logic        is_empty
);

	localparam int              CW      = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0]   DEPTH_C = CW'(QUEUE_DEPTH);

	logic                     acc;
	logic                     full;
	logic                     empty;
	logic [31:0]              id_ext;
	logic [ID_BITS-1:0]       key;
	fkr_pkg::cell_ctrl_t      ctrl;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            count_n;
	logic [1:0]               code;
	logic [31:0]              taken_ext;
	logic [31:0]              count_ext;

	logic [ID_BITS-1:0]       cell_data   [QUEUE_DEPTH];
	logic [ID_BITS-1:0]       taken_chain [QUEUE_DEPTH+1];
	logic                     found_chain [QUEUE_DEPTH+1];
	logic [QUEUE_DEPTH-1:0]   take_vec;

	logic                     out_valid_q;
	logic [1:0]               result_code_q;
	logic [15:0]              removed_id_q;
	logic [4:0]               entry_total_q;
	logic                     is_empty_q;

	assign in_stall = out_valid_q && out_stall;
	assign acc      = in_valid && !in_stall;
	assign full     = count_q == DEPTH_C;
	assign empty    = count_q == '0;
	assign id_ext   = {16'b0, id};
	assign key      = id_ext[ID_BITS-1:0];

	always_comb begin
		ctrl.push   = acc && cmd == fkr_pkg::CMD_PUSH && !full;
		ctrl.pop    = acc && cmd == fkr_pkg::CMD_POP;
		ctrl.search = acc && cmd == fkr_pkg::CMD_REMOVE;
	end

	assign found_chain[0] = 1'b0;
	assign taken_chain[0] = '0;

	for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
		logic [ID_BITS-1:0] nbr;
		if (k == QUEUE_DEPTH - 1) begin : g_last
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = cell_data[k+1];
		end

		fkr_cell #(
			.ID_BITS (ID_BITS),
			.CW      (CW),
			.IDX     (k)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.key       (key),
			.count     (count_q),
			.nbr_data  (nbr),
			.found_in  (found_chain[k]),
			.taken_in  (taken_chain[k]),
			.data      (cell_data[k]),
			.found_out (found_chain[k+1]),
			.taken_out (taken_chain[k+1]),
			.take      (take_vec[k])
		);
	end

	always_comb begin
		count_n = count_q;
		code    = fkr_pkg::RC_OK;
		case (cmd)
			fkr_pkg::CMD_PUSH: begin
				if (full) begin
					code = fkr_pkg::RC_FULL;
				end else begin
					count_n = count_q + CW'(1);
				end
			end
			fkr_pkg::CMD_POP: begin
				if (empty) begin
					code = fkr_pkg::RC_EMPTY;
				end else begin
					count_n = count_q - CW'(1);
				end
			end
			fkr_pkg::CMD_REMOVE: begin
				if (found_chain[QUEUE_DEPTH]) begin
					count_n = count_q - CW'(1);
				end else begin
					code = fkr_pkg::RC_NOT_FOUND;
				end
			end
			default: begin
			end
		endcase
	end

	assign taken_ext = 32'(taken_chain[QUEUE_DEPTH]);
	assign count_ext = 32'(count_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (acc) begin
				out_valid_q <= 1'b1;
				count_q     <= count_n;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			result_code_q <= code;
			removed_id_q  <= taken_ext[15:0];
			entry_total_q <= count_ext[4:0];
			is_empty_q    <= count_n == '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_code = result_code_q;
	assign removed_id  = removed_id_q;
	assign entry_total = entry_total_q;
	assign is_empty    = is_empty_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count above depth");

	a_single_take: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(take_vec))
		else $error("more than one cell taken");

	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		acc && cmd == fkr_pkg::CMD_PUSH && full |=> $stable(count_q))
		else $error("push on full queue changed count");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> out_valid_q && (is_empty_q == (count_q == '0)))
		else $error("empty flag disagrees with count");

	a_take_count: assert property (@(posedge clk) disable iff (!arst_n)
		acc && found_chain[QUEUE_DEPTH] |=> count_q == $past(count_q) - CW'(1))
		else $error("removal did not drop count");

endmodule

FILE: hdl/fkr_cell.sv
// one queue slot: match, first-hit chain, shift toward head, tail load
module fkr_cell #(
	parameter int ID_BITS = 16,
	parameter int CW      = 5,
	parameter int IDX     = 0
) (
	input  logic                clk,
	input  fkr_pkg::cell_ctrl_t ctrl,
	input  logic [ID_BITS-1:0]  key,
	input  logic [CW-1:0]       count,
	input  logic [ID_BITS-1:0]  nbr_data,
	input  logic                found_in,
	input  logic [ID_BITS-1:0]  taken_in,
	output logic [ID_BITS-1:0]  data,
	output logic                found_out,
	output logic [ID_BITS-1:0]  taken_out,
	output logic                take
);

	localparam logic [CW-1:0] IDX_C = CW'(IDX);

	logic [ID_BITS-1:0] data_q;
	logic               occupied;
	logic               head_pop;

	always_comb begin
		occupied  = IDX_C < count;
		head_pop  = (IDX == 0) && ctrl.pop;
		take      = !found_in && occupied && (head_pop || (ctrl.search && data_q == key));
		found_out = found_in | take;
		taken_out = taken_in | (take ? data_q : '0);
	end

	always_ff @(posedge clk) begin
		if (found_out) begin
			data_q <= nbr_data;
		end else if (ctrl.push && count == IDX_C) begin
			data_q <= key;
		end
	end

	assign data = data_q;

endmodule
